FILE: hdl/psd_pkg.sv
// shared constants, types and codes for the point to segment distance block
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int FRAC2      = 2 * FRAC_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int NUM_W      = 2 * SQ_W;
  localparam int QUO_W      = SQ_W + FRAC2;
  localparam int ROOT_W     = (QUO_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int DIST_W     = 17;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INTERIOR   = 2'd0,
    KIND_FIRST      = 2'd1,
    KIND_SECOND     = 2'd2,
    KIND_DEGENERATE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } seg_t;

  // work for the back end: floor(num * 4^F / den), then a square root
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [SQ_W-1:0]  den;
    kind_e            kind;
  } item_t;

endpackage
`default_nettype wire

FILE: hdl/point_segment_distance.sv
// top level of the point to segment distance block
//
//  channel   signals                                   direction  request moved
//  point     point_valid_i/point_ready_o, point_x/y_i  in         one query point
//  result    result_valid_o/result_ready_i,
//            distance_q4_o, nearest_kind_o             out        distance and kind
//  config    cfg_we_i, cfg_index_i, cfg_data_i         in         one segment register
//
// one point is taken per cycle while the request queue has room; a point passes
// through 4 front stages, 1 queue slot, the divider stages (one quotient bit
// each), the square root stages (one root bit each) and the output register
// reset clears the segment registers to zero and empties all pipelines
// the front end stalls only when the request queue is full; the back end
// pipeline holds as a whole while a finished result waits to be taken
`default_nettype none
module point_segment_distance (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                point_valid_i,
  output logic                               point_ready_o,
  input  wire  [psd_pkg::COORD_BITS-1:0]     point_x_i,
  input  wire  [psd_pkg::COORD_BITS-1:0]     point_y_i,
  output logic                               result_valid_o,
  input  wire                                result_ready_i,
  output logic [psd_pkg::DIST_W-1:0]         distance_q4_o,
  output logic [psd_pkg::KIND_W-1:0]         nearest_kind_o,
  input  wire                                cfg_we_i,
  input  wire  [psd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [psd_pkg::COORD_BITS-1:0]     cfg_data_i
);

  // segment endpoints; the user must write them only while idle, the block does not enforce it
  psd_pkg::seg_t seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        psd_pkg::REG_SEG_START_X: seg_q.ax <= cfg_data_i;
        psd_pkg::REG_SEG_START_Y: seg_q.ay <= cfg_data_i;
        psd_pkg::REG_SEG_END_X:   seg_q.bx <= cfg_data_i;
        psd_pkg::REG_SEG_END_Y:   seg_q.by <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end to queue
  logic           f_valid, f_ready;
  psd_pkg::item_t f_item;
  // queue to back end
  logic           b_valid, b_ready;
  psd_pkg::item_t b_item;

  psd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (point_valid_i),
    .ready_o      (point_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .seg_i        (seg_q),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  psd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  psd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .valid_o      (result_valid_o),
    .ready_i      (result_ready_i),
    .distance_o   (distance_q4_o),
    .kind_o       (nearest_kind_o)
  );

endmodule
`default_nettype wire

FILE: hdl/psd_front.sv
// front end: differences, squared lengths, classification, dividend set-up
`default_nettype none
module psd_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              valid_i,
  output logic                             ready_o,
  input  wire  [psd_pkg::COORD_BITS-1:0]   point_x_i,
  input  wire  [psd_pkg::COORD_BITS-1:0]   point_y_i,
  input  psd_pkg::seg_t                    seg_i,
  output logic                             item_valid_o,
  input  wire                              item_ready_i,
  output psd_pkg::item_t                   item_o
);

  logic en;

  // stage a: coordinate differences
  logic va_q;
  logic signed [psd_pkg::DIFF_W-1:0] pax_q, pay_q, pbx_q, pby_q, abx_q, aby_q;
  // stage b: squared lengths and cross terms
  logic vb_q;
  logic [psd_pkg::SQ_W-1:0] a2_q, b2_q, c2_q;
  logic signed [psd_pkg::PROD_W-1:0] cr1_q, cr2_q;
  // stage c: classification
  logic vc_q;
  psd_pkg::kind_e kind_q;
  logic [psd_pkg::SQ_W-1:0] d2_q, mag_q, c2c_q;
  logic int_q;
  // stage d: dividend
  logic vd_q;
  psd_pkg::item_t item_q;

  assign en           = !vd_q || item_ready_i;
  assign ready_o      = en;
  assign item_valid_o = vd_q;
  assign item_o       = item_q;

  logic signed [psd_pkg::PROD_W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [psd_pkg::PROD_W:0]   cr;
  logic [psd_pkg::PROD_W:0]          cr_abs;
  logic [psd_pkg::SQ_W:0]            sum_bc, sum_ac;
  psd_pkg::kind_e                    kind_d;
  logic [psd_pkg::SQ_W-1:0]          d2_d;
  logic                              int_d;

  always_comb begin
    sq_ax = pax_q * pax_q;
    sq_ay = pay_q * pay_q;
    sq_bx = pbx_q * pbx_q;
    sq_by = pby_q * pby_q;
    sq_cx = abx_q * abx_q;
    sq_cy = aby_q * aby_q;
  end

  always_comb begin
    cr     = (psd_pkg::PROD_W+1)'(cr1_q) - (psd_pkg::PROD_W+1)'(cr2_q);
    cr_abs = cr[psd_pkg::PROD_W] ? unsigned'(-cr) : unsigned'(cr);
    sum_bc = (psd_pkg::SQ_W+1)'(b2_q) + (psd_pkg::SQ_W+1)'(c2_q);
    sum_ac = (psd_pkg::SQ_W+1)'(a2_q) + (psd_pkg::SQ_W+1)'(c2_q);
    int_d  = 1'b0;
    if (a2_q == '0) begin
      kind_d = psd_pkg::KIND_FIRST;
      d2_d   = '0;
    end else if (b2_q == '0) begin
      kind_d = psd_pkg::KIND_SECOND;
      d2_d   = '0;
    end else if (c2_q == '0) begin
      kind_d = psd_pkg::KIND_DEGENERATE;
      d2_d   = a2_q;
    end else if ((psd_pkg::SQ_W+1)'(a2_q) >= sum_bc) begin
      kind_d = psd_pkg::KIND_SECOND;
      d2_d   = b2_q;
    end else if ((psd_pkg::SQ_W+1)'(b2_q) >= sum_ac) begin
      kind_d = psd_pkg::KIND_FIRST;
      d2_d   = a2_q;
    end else begin
      kind_d = psd_pkg::KIND_INTERIOR;
      d2_d   = '0;
      int_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pax_q <= psd_pkg::DIFF_W'(point_x_i) - psd_pkg::DIFF_W'(seg_i.ax);
      pay_q <= psd_pkg::DIFF_W'(point_y_i) - psd_pkg::DIFF_W'(seg_i.ay);
      pbx_q <= psd_pkg::DIFF_W'(point_x_i) - psd_pkg::DIFF_W'(seg_i.bx);
      pby_q <= psd_pkg::DIFF_W'(point_y_i) - psd_pkg::DIFF_W'(seg_i.by);
      abx_q <= psd_pkg::DIFF_W'(seg_i.bx) - psd_pkg::DIFF_W'(seg_i.ax);
      aby_q <= psd_pkg::DIFF_W'(seg_i.by) - psd_pkg::DIFF_W'(seg_i.ay);

      a2_q  <= psd_pkg::SQ_W'(sq_ax) + psd_pkg::SQ_W'(sq_ay);
      b2_q  <= psd_pkg::SQ_W'(sq_bx) + psd_pkg::SQ_W'(sq_by);
      c2_q  <= psd_pkg::SQ_W'(sq_cx) + psd_pkg::SQ_W'(sq_cy);
      cr1_q <= abx_q * pay_q;
      cr2_q <= aby_q * pax_q;

      kind_q <= kind_d;
      d2_q   <= d2_d;
      mag_q  <= psd_pkg::SQ_W'(cr_abs);
      c2c_q  <= c2_q;
      int_q  <= int_d;

      item_q.kind <= kind_q;
      if (int_q) begin
        item_q.num <= mag_q * mag_q;
        item_q.den <= c2c_q;
      end else begin
        item_q.num <= psd_pkg::NUM_W'(d2_q);
        item_q.den <= psd_pkg::SQ_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/psd_fifo.sv
// short request queue between front and back end
`default_nettype none
module psd_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  psd_pkg::item_t       push_item_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output psd_pkg::item_t       pop_item_o
);

  psd_pkg::item_t mem_q [psd_pkg::FIFO_DEPTH];
  logic [psd_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [psd_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != psd_pkg::FIFO_CNT_W'(psd_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule
`default_nettype wire

FILE: hdl/psd_back.sv
// back end: pipelined restoring divider followed by pipelined square root
`default_nettype none
module psd_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            item_valid_i,
  output logic                           item_ready_o,
  input  psd_pkg::item_t                 item_i,
  output logic                           valid_o,
  input  wire                            ready_i,
  output logic [psd_pkg::DIST_W-1:0]     distance_o,
  output logic [psd_pkg::KIND_W-1:0]     kind_o
);

  localparam int DS = psd_pkg::QUO_W;
  localparam int RS = psd_pkg::ROOT_W;

  logic en;

  logic                        dv_v_q   [DS+1];
  logic [psd_pkg::SQ_W-1:0]    dv_rem_q [DS+1];
  logic [psd_pkg::QUO_W-1:0]   dv_lo_q  [DS+1];
  logic [psd_pkg::SQ_W-1:0]    dv_den_q [DS+1];
  psd_pkg::kind_e              dv_kind_q[DS+1];
  logic [psd_pkg::SQ_W-1:0]    dv_rem_d [DS];
  logic [psd_pkg::QUO_W-1:0]   dv_lo_d  [DS];

  logic                        sq_v_q   [RS+1];
  logic [psd_pkg::SREM_W-1:0]  sq_rem_q [RS+1];
  logic [psd_pkg::ROOT_W-1:0]  sq_root_q[RS+1];
  logic [psd_pkg::RAD_W-1:0]   sq_rad_q [RS+1];
  psd_pkg::kind_e              sq_kind_q[RS+1];
  logic [psd_pkg::SREM_W-1:0]  sq_rem_d [RS];
  logic [psd_pkg::ROOT_W-1:0]  sq_root_d[RS];

  logic                        out_v_q;
  logic [psd_pkg::DIST_W-1:0]  dist_q;
  psd_pkg::kind_e              kind_q;

  assign en           = !out_v_q || ready_i;
  assign item_ready_o = en;
  assign valid_o      = out_v_q;
  assign distance_o   = dist_q;
  assign kind_o       = kind_q;

  // one quotient bit per stage
  always_comb begin
    logic [psd_pkg::SQ_W:0] t;
    logic ge;
    for (int k = 0; k < DS; k++) begin
      t  = {dv_rem_q[k], dv_lo_q[k][psd_pkg::QUO_W-1]};
      ge = t >= {1'b0, dv_den_q[k]};
      dv_rem_d[k] = ge ? psd_pkg::SQ_W'(t - {1'b0, dv_den_q[k]}) : psd_pkg::SQ_W'(t);
      dv_lo_d[k]  = {dv_lo_q[k][psd_pkg::QUO_W-2:0], ge};
    end
  end

  // one root bit per stage
  always_comb begin
    logic [psd_pkg::SREM_W+1:0] t;
    logic [psd_pkg::SREM_W+1:0] trial;
    logic ge;
    for (int k = 0; k < RS; k++) begin
      t     = {sq_rem_q[k], sq_rad_q[k][psd_pkg::RAD_W-1 -: 2]};
      trial = (psd_pkg::SREM_W+2)'({sq_root_q[k], 2'b01});
      ge    = t >= trial;
      sq_rem_d[k]  = ge ? psd_pkg::SREM_W'(t - trial) : psd_pkg::SREM_W'(t);
      sq_root_d[k] = {sq_root_q[k][psd_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DS; k++) dv_v_q[k] <= 1'b0;
      for (int k = 0; k <= RS; k++) sq_v_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= item_valid_i;
      for (int k = 0; k < DS; k++) dv_v_q[k+1] <= dv_v_q[k];
      sq_v_q[0] <= dv_v_q[DS];
      for (int k = 0; k < RS; k++) sq_v_q[k+1] <= sq_v_q[k];
      out_v_q <= sq_v_q[RS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0]  <= item_i.num[psd_pkg::NUM_W-1:psd_pkg::SQ_W];
      dv_lo_q[0]   <= psd_pkg::QUO_W'(item_i.num[psd_pkg::SQ_W-1:0]) << psd_pkg::FRAC2;
      dv_den_q[0]  <= item_i.den;
      dv_kind_q[0] <= item_i.kind;
      for (int k = 0; k < DS; k++) begin
        dv_rem_q[k+1]  <= dv_rem_d[k];
        dv_lo_q[k+1]   <= dv_lo_d[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_kind_q[k+1] <= dv_kind_q[k];
      end
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= psd_pkg::RAD_W'(dv_lo_q[DS]);
      sq_kind_q[0] <= dv_kind_q[DS];
      for (int k = 0; k < RS; k++) begin
        sq_rem_q[k+1]  <= sq_rem_d[k];
        sq_root_q[k+1] <= sq_root_d[k];
        sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
        sq_kind_q[k+1] <= sq_kind_q[k];
      end
      dist_q <= psd_pkg::DIST_W'(sq_root_q[RS]);
      kind_q <= sq_kind_q[RS];
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the point to segment distance block
`timescale 1ns / 100ps

// holds the expected distances and kinds and compares the block's results
class dist_scoreboard;
  logic [psd_pkg::DIST_W-1:0] exp_dist_q[$];
  psd_pkg::kind_e             exp_kind_q[$];
  int                         errors;
  int                         checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  function void note_point(logic [psd_pkg::DIST_W-1:0] d, psd_pkg::kind_e k);
    exp_dist_q = {exp_dist_q, d};
    exp_kind_q = {exp_kind_q, k};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [psd_pkg::DIST_W-1:0] d, logic [1:0] k);
    logic [psd_pkg::DIST_W-1:0] ed;
    psd_pkg::kind_e             ek;
    if (exp_dist_q.size() == 0) begin
      report($sformatf("unexpected result dist=%0d kind=%0d", d, k));
      return;
    end
    ed = exp_dist_q.pop_front();
    ek = exp_kind_q.pop_front();
    checked++;
    if (d !== ed) report($sformatf("distance got %0d want %0d", d, ed));
    if (k !== ek) report($sformatf("kind got %0d want %0d", k, ek));
  endtask
endclass

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           point_valid_i = 1'b0;
  logic                           point_ready_o;
  logic [psd_pkg::COORD_BITS-1:0] point_x_i = '0;
  logic [psd_pkg::COORD_BITS-1:0] point_y_i = '0;
  logic                           result_valid_o;
  logic                           result_ready_i = 1'b0;
  logic [psd_pkg::DIST_W-1:0]     distance_q4_o;
  logic [psd_pkg::KIND_W-1:0]     nearest_kind_o;
  logic                           cfg_we_i = 1'b0;
  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [psd_pkg::COORD_BITS-1:0] cfg_data_i = '0;

  dist_scoreboard sb = new();

  // idling percentages, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold     = 1'b0;
  int stall_count   = 0;
  int sent_points   = 0;
  int seg_count     = 0;

  // segment copy for prediction
  psd_pkg::seg_t seg;

  always #5 clk_i = ~clk_i;

  point_segment_distance dut (.*);

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [psd_pkg::DIST_W-1:0] sat_dist(longint unsigned r);
    return (r > 131071) ? psd_pkg::DIST_W'(131071) : psd_pkg::DIST_W'(r);
  endfunction

  // expected distance and kind for a point against the current segment
  task automatic predict_distance(input logic [psd_pkg::COORD_BITS-1:0] px_u,
                                  input logic [psd_pkg::COORD_BITS-1:0] py_u);
    longint px, py, ax, ay, bx, by, cr;
    longint unsigned a2, b2, c2, mag, num, v;
    logic [psd_pkg::DIST_W-1:0] d;
    psd_pkg::kind_e k;
    px = px_u; py = py_u;
    ax = seg.ax; ay = seg.ay; bx = seg.bx; by = seg.by;
    a2 = (px-ax)*(px-ax) + (py-ay)*(py-ay);
    b2 = (px-bx)*(px-bx) + (py-by)*(py-by);
    c2 = (bx-ax)*(bx-ax) + (by-ay)*(by-ay);
    if (a2 == 0) begin
      d = '0; k = psd_pkg::KIND_FIRST;
    end else if (b2 == 0) begin
      d = '0; k = psd_pkg::KIND_SECOND;
    end else if (c2 == 0) begin
      d = sat_dist(root_floor(a2 << psd_pkg::FRAC2)); k = psd_pkg::KIND_DEGENERATE;
    end else if (a2 >= b2 + c2) begin
      d = sat_dist(root_floor(b2 << psd_pkg::FRAC2)); k = psd_pkg::KIND_SECOND;
    end else if (b2 >= a2 + c2) begin
      d = sat_dist(root_floor(a2 << psd_pkg::FRAC2)); k = psd_pkg::KIND_FIRST;
    end else begin
      // perpendicular foot, exact quotient with fraction bits
      cr  = (bx-ax)*(py-ay) - (by-ay)*(px-ax);
      mag = (cr < 0) ? longint'(-cr) : longint'(cr);
      num = mag * mag;
      v   = ((num / c2) << psd_pkg::FRAC2) + (((num % c2) << psd_pkg::FRAC2) / c2);
      d   = sat_dist(root_floor(v));
      k   = psd_pkg::KIND_INTERIOR;
    end
    sb.note_point(d, k);
  endtask

  // register write while idle; the caller drops the write enable
  task automatic write_reg(input logic [psd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psd_pkg::COORD_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      psd_pkg::REG_SEG_START_X: seg.ax = val;
      psd_pkg::REG_SEG_START_Y: seg.ay = val;
      psd_pkg::REG_SEG_END_X:   seg.bx = val;
      default:                  seg.by = val;
    endcase
  endtask

  // stop offering points, wait for every expected result, then some slack
  task automatic drain();
    point_valid_i <= 1'b0;
    while (sb.exp_dist_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_segment(input logic [psd_pkg::COORD_BITS-1:0] ax, ay, bx, by);
    drain();
    write_reg(psd_pkg::REG_SEG_START_X, ax);
    write_reg(psd_pkg::REG_SEG_START_Y, ay);
    write_reg(psd_pkg::REG_SEG_END_X, bx);
    write_reg(psd_pkg::REG_SEG_END_Y, by);
    cfg_we_i <= 1'b0;
    seg_count++;
  endtask

  // one point request with optional idle cycles before it; valid stays high
  // after the accept until the next request or a drain replaces it
  task automatic send_point(input logic [psd_pkg::COORD_BITS-1:0] x,
                            input logic [psd_pkg::COORD_BITS-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      point_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    point_valid_i <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    @(posedge clk_i);
    while (!point_ready_o) @(posedge clk_i);
    predict_distance(x, y);
    sent_points++;
  endtask

  // points near the segment so every rule is hit
  function automatic logic [psd_pkg::COORD_BITS-1:0] near_coord(
      logic [psd_pkg::COORD_BITS-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(64)) - 32;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return psd_pkg::COORD_BITS'(t);
  endfunction

  task automatic random_points(input int n);
    logic [psd_pkg::COORD_BITS-1:0] x, y;
    int sel, t;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        x = seg.ax; y = seg.ay;
      end else if (sel == 1) begin
        x = seg.bx; y = seg.by;
      end else if (sel < 6) begin
        // around a point on the segment
        t = $urandom_range(16);
        x = near_coord(psd_pkg::COORD_BITS'((int'(seg.ax)*(16-t) + int'(seg.bx)*t) / 16));
        y = near_coord(psd_pkg::COORD_BITS'((int'(seg.ay)*(16-t) + int'(seg.by)*t) / 16));
      end else begin
        x = psd_pkg::COORD_BITS'($urandom);
        y = psd_pkg::COORD_BITS'($urandom);
      end
      send_point(x, y);
    end
  endtask

  task automatic random_segment();
    logic [psd_pkg::COORD_BITS-1:0] ax, ay;
    ax = psd_pkg::COORD_BITS'($urandom);
    ay = psd_pkg::COORD_BITS'($urandom);
    if ($urandom_range(7) == 0)
      load_segment(ax, ay, psd_pkg::COORD_BITS'($urandom), psd_pkg::COORD_BITS'($urandom));
    else if ($urandom_range(5) == 0)
      // degenerate segment
      load_segment(ax, ay, ax, ay);
    else
      load_segment(ax, ay, psd_pkg::COORD_BITS'($urandom_range(4095)),
                   psd_pkg::COORD_BITS'($urandom_range(4095)));
  endtask

  // receiver: random idling, or a long hold when asked
  always @(posedge clk_i) begin
    if (result_valid_o && result_ready_i)
      sb.check_result(distance_q4_o, nearest_kind_o);
    if (recv_hold) result_ready_i <= 1'b0;
    else result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver stall counted in its own process
  task automatic hold_receiver(input int cycles);
    recv_hold = 1'b1;
    for (int i = 0; i < cycles; i++) @(posedge clk_i);
    recv_hold = 1'b0;
  endtask

  // watchdog on cycles with no request moved
  always @(posedge clk_i) begin
    if ((point_valid_i && point_ready_o) || (result_valid_o && result_ready_i))
      stall_count <= 0;
    else if (rst_ni)
      stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    seg = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset segment is degenerate at the origin
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4095);
    send_point(12'd0, 12'd4095);
    // full diagonal
    load_segment(12'd0, 12'd0, 12'd4095, 12'd4095);
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4095);
    send_point(12'd4095, 12'd0);
    send_point(12'd0, 12'd4095);
    send_point(12'd2048, 12'd2047);
    // horizontal segment: right angles at each end and beyond
    load_segment(12'd100, 12'd200, 12'd3000, 12'd200);
    send_point(12'd100, 12'd4095);
    send_point(12'd3000, 12'd0);
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4095);
    send_point(12'd1500, 12'd1200);
    send_point(12'd1500, 12'd200);
    // reversed, far degenerate
    load_segment(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4094);
    load_segment(12'd4095, 12'd0, 12'd0, 12'd4095);
    send_point(12'd0, 12'd0);
    send_point(12'd4095, 12'd4095);
    send_point(12'd2730, 12'd1365);

    // sender idles 20, receiver 55
    send_idle_pct = 20; recv_idle_pct = 55;
    for (int s = 0; s < 8; s++) begin
      random_segment();
      random_points(60);
    end

    // long receiver hold while points keep coming so the block fills up
    fork
      hold_receiver(400);
      random_points(150);
    join

    // sender pauses until everything is back
    drain();

    send_idle_pct = 55; recv_idle_pct = 20;
    for (int s = 0; s < 8; s++) begin
      random_segment();
      random_points(60);
    end

    send_idle_pct = 0; recv_idle_pct = 0;
    for (int s = 0; s < 7; s++) begin
      random_segment();
      random_points(60);
    end

    drain();
    $display("tb: %0d points over %0d segment settings, %0d results checked",
             sent_points, seg_count, sb.checked);
    $display("tb: covered endpoints, degenerate and interior cases with stalls");
    if (sb.errors == 0 && sb.exp_dist_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
